// ===== rtl/core/pgnt_pkg.sv =====
// Package for the PGN movetext tokenizer.
// Holds character codes, parameter defaults and the control word of a buffer cell.
// No dependencies.
package pgnt_pkg;

   localparam int TOKEN_MAX_DEFAULT   = 16;
   localparam int NESTING_MAX_DEFAULT = 255;

   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic       shift;
      logic       write;
      logic [7:0] write_char;
   } cell_ctl_type;

endpackage

// ===== rtl/core/pgn_movetext_tokenizer.sv =====
// Top level of the PGN movetext tokenizer.
// Depends on pgnt_pkg and pgnt_cell (token buffer chain).
//
// Usage:
//   req channel: one movetext byte per word (req_text_char), or an end-of-text
//   word (req_end_of_text = 1) that flushes the pending token and clears all
//   parser state.
//   rsp channel: one token character per word, rsp_token_last on the final
//   character, rsp_token_truncated on every character of a token that had a
//   character other than ! or ? beyond the first TOKEN_MAX characters.
//   A byte that does not end a kept token leaves req_ready high. A byte that
//   ends a kept token starts the drain: the token is shifted out of the cell
//   chain one character per cycle while rsp_ready is high, head cell first.
//   req_ready is low while the chain drains.
//   The first character of a token is on rsp in the cycle after the
//   delimiter is accepted.
//   Reset: synchronous; clears parser state and drops any pending output.
//   Buffer contents need no clearing.
//   Stall: while rsp_ready is low the chain holds and the output word stays.
module pgn_movetext_tokenizer
   import pgnt_pkg::*;
#(
   parameter int TOKEN_MAX   = TOKEN_MAX_DEFAULT,
   parameter int NESTING_MAX = NESTING_MAX_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_last,
   output logic       rsp_token_truncated
);

   localparam int LEN_W   = $clog2(TOKEN_MAX + 1);
   localparam int DEPTH_W = $clog2(NESTING_MAX + 1);

   typedef enum logic [1:0] {
      SHAPE_EMPTY,
      SHAPE_DIGITS,
      SHAPE_DOTS,
      SHAPE_BAD
   } shape_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic               comment_ff, comment_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [LEN_W-1:0]   kept_ff, kept_in;
   logic               overflow_ff, overflow_in;
   shape_type          shape_ff, shape_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic               trunc_ff, trunc_in;

   logic               req_acc, rsp_acc;
   logic               flush, append, shift;
   logic               is_mark, is_digit, is_blank, full, drop, keep_token;
   logic [7:0]         chr;
   logic [7:0]         buf_q [TOKEN_MAX];
   cell_ctl_type       ctl   [TOKEN_MAX];

   assign req_acc = req_valid & req_ready;
   assign rsp_acc = rsp_valid & rsp_ready;
   assign chr     = req_text_char;

   assign is_mark  = (chr == CH_BANG) || (chr == CH_QUEST);
   assign is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
   assign is_blank = chr inside {CH_SPACE, [CH_TAB:CH_CR]};
   assign full     = (length_ff == LEN_W'(TOKEN_MAX));

   assign drop = (shape_ff == SHAPE_DIGITS) || (shape_ff == SHAPE_DOTS)
      || (buf_q[0] == CH_DOLLAR)
      || (length_ff == LEN_W'(3) && buf_q[0] == CH_ONE && buf_q[1] == CH_DASH
          && buf_q[2] == CH_ZERO)
      || (length_ff == LEN_W'(3) && buf_q[0] == CH_ZERO && buf_q[1] == CH_DASH
          && buf_q[2] == CH_ONE)
      || (length_ff == LEN_W'(7) && buf_q[0] == CH_ONE && buf_q[1] == CH_SLASH
          && buf_q[2] == CH_TWO && buf_q[3] == CH_DASH && buf_q[4] == CH_ONE
          && buf_q[5] == CH_SLASH && buf_q[6] == CH_TWO)
      || (length_ff == LEN_W'(1) && buf_q[0] == CH_STAR);

   assign keep_token = (length_ff != '0) && !drop && (kept_ff != '0);

   always_comb begin
      state_in    = state_ff;
      comment_in  = comment_ff;
      depth_in    = depth_ff;
      length_in   = length_ff;
      kept_in     = kept_ff;
      overflow_in = overflow_ff;
      shape_in    = shape_ff;
      count_in    = count_ff;
      trunc_in    = trunc_ff;
      flush       = 1'b0;
      append      = 1'b0;
      shift       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_end_of_text) begin
                  flush      = 1'b1;
                  comment_in = 1'b0;
                  depth_in   = '0;
               end else if (comment_ff) begin
                  if (chr == CH_RBRACE) begin
                     comment_in = 1'b0;
                  end
               end else if (chr == CH_LBRACE) begin
                  flush      = 1'b1;
                  comment_in = 1'b1;
               end else if (chr == CH_LPAREN) begin
                  flush = 1'b1;
                  if (depth_ff != DEPTH_W'(NESTING_MAX)) begin
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end else if (chr == CH_RPAREN) begin
                  flush = 1'b1;
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - DEPTH_W'(1);
                  end
               end else if (is_blank) begin
                  flush = 1'b1;
               end else if (depth_ff == '0) begin
                  append = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               shift    = 1'b1;
               count_in = count_ff - LEN_W'(1);
               if (count_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (flush) begin
         if (keep_token) begin
            state_in = ST_EMIT;
            count_in = kept_ff;
            trunc_in = overflow_ff;
         end
         length_in   = '0;
         kept_in     = '0;
         overflow_in = 1'b0;
         shape_in    = SHAPE_EMPTY;
      end

      if (append) begin
         case (shape_ff)
            SHAPE_EMPTY:  shape_in = is_digit ? SHAPE_DIGITS : SHAPE_BAD;
            SHAPE_DIGITS: shape_in = is_digit ? SHAPE_DIGITS
                                   : ((chr == CH_DOT) ? SHAPE_DOTS : SHAPE_BAD);
            SHAPE_DOTS:   shape_in = (chr == CH_DOT) ? SHAPE_DOTS : SHAPE_BAD;
            default:      shape_in = SHAPE_BAD;
         endcase
         if (!full) begin
            length_in = length_ff + LEN_W'(1);
            if (!is_mark) begin
               kept_in = length_ff + LEN_W'(1);
            end
         end else if (!is_mark) begin
            overflow_in = 1'b1;
            kept_in     = LEN_W'(TOKEN_MAX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         comment_ff  <= 1'b0;
         depth_ff    <= '0;
         length_ff   <= '0;
         kept_ff     <= '0;
         overflow_ff <= 1'b0;
         shape_ff    <= SHAPE_EMPTY;
         count_ff    <= '0;
         trunc_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         comment_ff  <= comment_in;
         depth_ff    <= depth_in;
         length_ff   <= length_in;
         kept_ff     <= kept_in;
         overflow_ff <= overflow_in;
         shape_ff    <= shape_in;
         count_ff    <= count_in;
         trunc_ff    <= trunc_in;
      end
   end

   for (genvar i = 0; i < TOKEN_MAX; i++) begin : g_chain
      logic [7:0] next_char;

      assign ctl[i].shift      = shift;
      assign ctl[i].write      = append && !full && (length_ff == LEN_W'(i));
      assign ctl[i].write_char = chr;

      if (i == TOKEN_MAX - 1) begin : g_tail
         assign next_char = 8'h00;
      end else begin : g_body
         assign next_char = buf_q[i+1];
      end

      pgnt_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .next_char (next_char),
         .char_q    (buf_q[i])
      );
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_EMIT);
   assign rsp_token_char      = buf_q[0];
   assign rsp_token_last      = (count_ff == LEN_W'(1));
   assign rsp_token_truncated = trunc_ff;

   a_emit_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("output word with no characters left");

   a_length_bound : assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(TOKEN_MAX) && kept_ff <= length_ff)
      else $error("token length out of bounds");

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(NESTING_MAX))
      else $error("nesting depth beyond maximum");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_token_last |=> req_ready)
      else $error("input not resumed after last character");

endmodule

// ===== rtl/core/pgnt_cell.sv =====
// One character cell of the token buffer chain.
// Depends on pgnt_pkg for the cell control word.
module pgnt_cell
   import pgnt_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [7:0]   next_char,
   output logic [7:0]   char_q
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = next_char;
      end else if (ctl.write) begin
         data_in = ctl.write_char;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign char_q = data_ff;

endmodule
